// File: rtl/lppd_pkg.sv
// Shared widths, register indexes and control types for the line position PID drive.
package lppd_pkg;

  // Fixed field widths
  localparam int SENSOR_W   = 6;
  localparam int SPEED_W    = 9;
  localparam int POS_W      = 11;
  localparam int INTEG_W    = 15;
  localparam int GAIN_W     = 16;
  localparam int BYTE_W     = 8;
  localparam int LIM_W      = 14;
  localparam int CORR_W     = 11;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int DIVISOR_W  = 3;

  // Correction magnitude beyond which both wheels saturate anyway
  localparam int CORR_LIMIT = 512;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CRUISE_SPEED   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SPEED_CAP      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_CAP       = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_INTEGRAL_LIMIT = 3'd6;

  // Register reset values
  localparam logic [GAIN_W-1:0] PROP_GAIN_RST      = 16'd12800;
  localparam logic [GAIN_W-1:0] INTEG_GAIN_RST     = 16'd77;
  localparam logic [GAIN_W-1:0] DERIV_GAIN_RST     = 16'd1152;
  localparam logic [BYTE_W-1:0] CRUISE_SPEED_RST   = 8'd80;
  localparam logic [BYTE_W-1:0] SPEED_CAP_RST      = 8'd120;
  localparam logic [BYTE_W-1:0] STEP_CAP_RST       = 8'd10;
  localparam logic [LIM_W-1:0]  INTEGRAL_LIMIT_RST = 14'd12800;

  // Controls of the shared multiply-accumulate unit
  typedef struct packed {
    logic mul_en;   // capture gain * operand
    logic acc_clr;  // zero the accumulator
    logic acc_en;   // add the captured product
  } mac_ctrl_t;

endpackage

// File: rtl/lppd_div.sv
// Bit-serial restoring divider for the sensor weight mean.
module lppd_div #(
  parameter int NUM_W = 11
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic [NUM_W-1:0]                   numer,
  input  logic [lppd_pkg::DIVISOR_W-1:0]     denom,
  output logic                               busy,
  output logic                               done,
  output logic [NUM_W-1:0]                   quot
);

  localparam int CNT_W = $clog2(NUM_W);
  localparam int REM_W = lppd_pkg::DIVISOR_W;

  logic [NUM_W-1:0] work;
  logic [REM_W-1:0] rem;
  logic [REM_W-1:0] divisor;
  logic [CNT_W-1:0] cnt;
  logic [REM_W:0]   trial;
  logic             fits;

  // One quotient bit per cycle: shift the next numerator bit into the remainder
  assign trial = {rem, work[NUM_W-1]};
  assign fits  = trial >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(NUM_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Hold the remainder and the numerator/quotient shift register
  always_ff @(posedge clk) begin
    if (start) begin
      work    <= numer;
      rem     <= '0;
      divisor <= denom;
    end else if (busy) begin
      work <= {work[NUM_W-2:0], fits};
      rem  <= fits ? REM_W'(trial - {1'b0, divisor}) : trial[REM_W-1:0];
    end
  end

  assign quot = work;

endmodule

// File: rtl/lppd_mac.sv
// Shared multiply-accumulate unit for the three PID terms.
module lppd_mac #(
  parameter int OPND_W = 16,
  parameter int ACC_W  = 35
) (
  input  logic                              clk,
  input  lppd_pkg::mac_ctrl_t               ctrl,
  input  logic [lppd_pkg::GAIN_W-1:0]       gain,
  input  logic signed [OPND_W-1:0]          opnd,
  output logic signed [ACC_W-1:0]           acc
);

  localparam int PROD_W = lppd_pkg::GAIN_W + 1 + OPND_W;

  logic signed [PROD_W-1:0] prod;

  // Register the product, then add it on the next step
  always_ff @(posedge clk) begin
    if (ctrl.mul_en) begin
      prod <= PROD_W'($signed({1'b0, gain}) * opnd);
    end
    if (ctrl.acc_clr) begin
      acc <= '0;
    end else if (ctrl.acc_en) begin
      acc <= acc + ACC_W'(prod);
    end
  end

endmodule

// File: rtl/lppd_drive.sv
// One wheel: offset the base speed, saturate, then limit the step against the last output.
module lppd_drive (
  input  logic [lppd_pkg::BYTE_W-1:0]         cruise_speed,
  input  logic [lppd_pkg::BYTE_W-1:0]         speed_cap,
  input  logic [lppd_pkg::BYTE_W-1:0]         step_cap,
  input  logic signed [lppd_pkg::CORR_W-1:0]  corr,
  input  logic signed [lppd_pkg::SPEED_W-1:0] prev,
  output logic signed [lppd_pkg::SPEED_W-1:0] speed
);

  localparam int W = lppd_pkg::CORR_W + 1;

  logic signed [W-1:0] target;
  logic signed [W-1:0] top;
  logic signed [W-1:0] sat;
  logic signed [W-1:0] lo;
  logic signed [W-1:0] hi;
  logic signed [W-1:0] slew;

  always_comb begin
    target = W'($signed({1'b0, cruise_speed})) + W'(corr);
    top    = W'($signed({1'b0, speed_cap}));
    // Saturate to the speed range
    if (target > top) begin
      sat = top;
    end else if (target < -top) begin
      sat = -top;
    end else begin
      sat = target;
    end
    // Limit the change against the previous output
    lo = W'(prev) - W'($signed({1'b0, step_cap}));
    hi = W'(prev) + W'($signed({1'b0, step_cap}));
    if (sat < lo) begin
      slew = lo;
    end else if (sat > hi) begin
      slew = hi;
    end else begin
      slew = sat;
    end
    speed = slew[lppd_pkg::SPEED_W-1:0];
  end

endmodule

// File: rtl/line_position_pid_drive.sv
// Line position PID drive: sensor decode, sequencer, integral, correction and output register.
// A sample with an active sensor passes through the bit-serial divider and then four passes
// through the shared multiply-accumulate unit before its result is registered; a sample with
// no active sensor skips the divider. The result waits in the wheel step while the output
// stalls. Input is taken again in the cycle after the result is registered, so the block
// takes no new sample while one is in progress.
// Reset clears the loop state and output valid, loads the register defaults; no clearing pass.
module line_position_pid_drive #(
  parameter int ERROR_FRAC_BITS = 8,
  parameter int GAIN_FRAC_BITS  = 8
) (
  input  logic                                clk,
  input  logic                                rst,
  // Sensor samples
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [7:0]                          s_axis_tdata,  // [5:0] sensor_bits
  // Wheel commands
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [31:0]                         m_axis_tdata,  // [8:0] left_speed,
                                                             // [17:9] right_speed,
                                                             // [28:18] position_error
  output logic [0:0]                          m_axis_tuser,  // [0] line_lost
  // Register writes
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [lppd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [lppd_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int ERR_W   = ERROR_FRAC_BITS + 3;
  localparam int DIFF_W  = ERR_W + 1;
  localparam int OPND_W  = (DIFF_W > lppd_pkg::INTEG_W) ? DIFF_W : lppd_pkg::INTEG_W;
  localparam int ACC_W   = lppd_pkg::GAIN_W + 1 + OPND_W + 2;
  localparam int SUM_W   = ((ERR_W > lppd_pkg::INTEG_W) ? ERR_W : lppd_pkg::INTEG_W) + 1;
  localparam int POSX_W  = (ERR_W > lppd_pkg::POS_W) ? ERR_W : lppd_pkg::POS_W;
  localparam int SHIFT   = ERROR_FRAC_BITS + GAIN_FRAC_BITS;
  localparam int SPEED_W = lppd_pkg::SPEED_W;
  localparam int CORR_W  = lppd_pkg::CORR_W;

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_DIV   = 4'd1;
  localparam logic [3:0] ST_INTEG = 4'd2;
  localparam logic [3:0] ST_MUL0  = 4'd3;
  localparam logic [3:0] ST_MUL1  = 4'd4;
  localparam logic [3:0] ST_MUL2  = 4'd5;
  localparam logic [3:0] ST_MUL3  = 4'd6;
  localparam logic [3:0] ST_SHIFT = 4'd7;
  localparam logic [3:0] ST_WHEEL = 4'd8;

  localparam logic signed [ACC_W-1:0] ROUND_ADD = ACC_W'((64'sd1 <<< SHIFT) - 64'sd1);
  localparam logic signed [ACC_W-1:0] CORR_HI   = ACC_W'(lppd_pkg::CORR_LIMIT);

  // Configuration registers
  logic [lppd_pkg::GAIN_W-1:0] prop_gain;
  logic [lppd_pkg::GAIN_W-1:0] integ_gain;
  logic [lppd_pkg::GAIN_W-1:0] deriv_gain;
  logic [lppd_pkg::BYTE_W-1:0] cruise_speed;
  logic [lppd_pkg::BYTE_W-1:0] speed_cap;
  logic [lppd_pkg::BYTE_W-1:0] step_cap;
  logic [lppd_pkg::LIM_W-1:0]  integral_limit;

  // Loop state
  logic signed [ERR_W-1:0]              previous_error;
  logic signed [lppd_pkg::INTEG_W-1:0]  error_integral;
  logic signed [SPEED_W-1:0]            previous_left_speed;
  logic signed [SPEED_W-1:0]            previous_right_speed;

  // Working registers
  logic [3:0]                state;
  logic signed [ERR_W-1:0]   err;
  logic signed [DIFF_W-1:0]  diff;
  logic                      lost;
  logic                      err_neg;
  logic signed [CORR_W-1:0]  corr;

  // Sensor decode
  logic signed [3:0]                     sens_sum;
  logic [lppd_pkg::DIVISOR_W-1:0]        sens_cnt;
  logic [2:0]                            sens_mag;
  logic                                  in_xfer;

  // Divider
  logic                  div_start;
  logic                  div_busy;
  logic                  div_done;
  logic [ERR_W-1:0]      div_quot;
  logic [ERR_W-1:0]      div_numer;

  // Multiply-accumulate
  lppd_pkg::mac_ctrl_t         mac_ctrl;
  logic [lppd_pkg::GAIN_W-1:0] mac_gain;
  logic signed [OPND_W-1:0]    mac_opnd;
  logic signed [ACC_W-1:0]     mac_acc;

  // Integral, correction and wheels
  logic signed [SUM_W-1:0]    integ_sum;
  logic signed [SUM_W-1:0]    integ_lim;
  logic signed [SUM_W-1:0]    integ_clamped;
  logic signed [ACC_W-1:0]    corr_full;
  logic signed [ACC_W-1:0]    corr_sat;
  logic signed [CORR_W-1:0]   corr_neg;
  logic signed [SPEED_W-1:0]  left_next;
  logic signed [SPEED_W-1:0]  right_next;
  logic signed [POSX_W-1:0]   err_x;
  logic                       out_load;
  logic signed [SPEED_W:0]    left_step;
  logic signed [SPEED_W:0]    right_step;

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = (state == ST_IDLE);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;

  // Write configuration registers; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      prop_gain      <= lppd_pkg::PROP_GAIN_RST;
      integ_gain     <= lppd_pkg::INTEG_GAIN_RST;
      deriv_gain     <= lppd_pkg::DERIV_GAIN_RST;
      cruise_speed   <= lppd_pkg::CRUISE_SPEED_RST;
      speed_cap      <= lppd_pkg::SPEED_CAP_RST;
      step_cap       <= lppd_pkg::STEP_CAP_RST;
      integral_limit <= lppd_pkg::INTEGRAL_LIMIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        lppd_pkg::REG_PROP_GAIN:      prop_gain      <= cfg_data;
        lppd_pkg::REG_INTEG_GAIN:     integ_gain     <= cfg_data;
        lppd_pkg::REG_DERIV_GAIN:     deriv_gain     <= cfg_data;
        lppd_pkg::REG_CRUISE_SPEED:   cruise_speed   <= cfg_data[lppd_pkg::BYTE_W-1:0];
        lppd_pkg::REG_SPEED_CAP:      speed_cap      <= cfg_data[lppd_pkg::BYTE_W-1:0];
        lppd_pkg::REG_STEP_CAP:       step_cap       <= cfg_data[lppd_pkg::BYTE_W-1:0];
        lppd_pkg::REG_INTEGRAL_LIMIT: integral_limit <= cfg_data[lppd_pkg::LIM_W-1:0];
        default: ;
      endcase
    end
  end

  // Sum the weights of the active sensors and count them
  always_comb begin
    sens_sum = '0;
    sens_cnt = '0;
    for (int i = 0; i < lppd_pkg::SENSOR_W; i++) begin
      if (s_axis_tdata[i]) begin
        sens_sum = sens_sum + ((i < 3) ? 4'(i - 3) : 4'(i - 2));
        sens_cnt = sens_cnt + 1'b1;
      end
    end
    sens_mag = sens_sum[3] ? 3'(-sens_sum) : sens_sum[2:0];
  end

  assign div_start = in_xfer && (sens_cnt != '0);
  assign div_numer = ERR_W'(sens_mag) << ERROR_FRAC_BITS;

  lppd_div #(
    .NUM_W (ERR_W)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .numer (div_numer),
    .denom (sens_cnt),
    .busy  (div_busy),
    .done  (div_done),
    .quot  (div_quot)
  );

  // Clamp the running integral
  always_comb begin
    integ_sum = SUM_W'(error_integral) + SUM_W'(err);
    integ_lim = SUM_W'($signed({1'b0, integral_limit}));
    if (integ_sum > integ_lim) begin
      integ_clamped = integ_lim;
    end else if (integ_sum < -integ_lim) begin
      integ_clamped = -integ_lim;
    end else begin
      integ_clamped = integ_sum;
    end
  end

  // Steer the shared unit through the three terms
  always_comb begin
    mac_ctrl = '0;
    mac_gain = prop_gain;
    mac_opnd = OPND_W'(err);
    case (state)
      ST_MUL0: begin
        mac_ctrl.mul_en  = 1'b1;
        mac_ctrl.acc_clr = 1'b1;
      end
      ST_MUL1: begin
        mac_ctrl.mul_en = 1'b1;
        mac_ctrl.acc_en = 1'b1;
        mac_gain        = integ_gain;
        mac_opnd        = OPND_W'(error_integral);
      end
      ST_MUL2: begin
        mac_ctrl.mul_en = 1'b1;
        mac_ctrl.acc_en = 1'b1;
        mac_gain        = deriv_gain;
        mac_opnd        = OPND_W'(diff);
      end
      ST_MUL3: begin
        mac_ctrl.acc_en = 1'b1;
      end
      default: ;
    endcase
  end

  lppd_mac #(
    .OPND_W (OPND_W),
    .ACC_W  (ACC_W)
  ) u_mac (
    .clk  (clk),
    .ctrl (mac_ctrl),
    .gain (mac_gain),
    .opnd (mac_opnd),
    .acc  (mac_acc)
  );

  // Drop the fraction bits toward zero, then bound the correction
  always_comb begin
    corr_full = mac_acc[ACC_W-1] ? ((mac_acc + ROUND_ADD) >>> SHIFT) : (mac_acc >>> SHIFT);
    if (corr_full > CORR_HI) begin
      corr_sat = CORR_HI;
    end else if (corr_full < -CORR_HI) begin
      corr_sat = -CORR_HI;
    end else begin
      corr_sat = corr_full;
    end
  end

  assign corr_neg = -corr;

  lppd_drive u_left (
    .cruise_speed (cruise_speed),
    .speed_cap    (speed_cap),
    .step_cap     (step_cap),
    .corr         (corr_neg),
    .prev         (previous_left_speed),
    .speed        (left_next)
  );

  lppd_drive u_right (
    .cruise_speed (cruise_speed),
    .speed_cap    (speed_cap),
    .step_cap     (step_cap),
    .corr         (corr),
    .prev         (previous_right_speed),
    .speed        (right_next)
  );

  assign out_load = (state == ST_WHEEL) && (!m_axis_tvalid || m_axis_tready);
  assign err_x    = POSX_W'(err);

  // Sequencer and loop state
  always_ff @(posedge clk) begin
    if (rst) begin
      state                <= ST_IDLE;
      previous_error       <= '0;
      error_integral       <= '0;
      previous_left_speed  <= '0;
      previous_right_speed <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_xfer) begin
            state <= (sens_cnt == '0) ? ST_INTEG : ST_DIV;
          end
        end
        ST_DIV: begin
          if (div_done) begin
            state <= ST_INTEG;
          end
        end
        ST_INTEG: begin
          error_integral <= lppd_pkg::INTEG_W'(integ_clamped);
          previous_error <= err;
          state          <= ST_MUL0;
        end
        ST_MUL0:  state <= ST_MUL1;
        ST_MUL1:  state <= ST_MUL2;
        ST_MUL2:  state <= ST_MUL3;
        ST_MUL3:  state <= ST_SHIFT;
        ST_SHIFT: state <= ST_WHEEL;
        ST_WHEEL: begin
          if (out_load) begin
            previous_left_speed  <= left_next;
            previous_right_speed <= right_next;
            state                <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Working values of the current sample
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      lost    <= (sens_cnt == '0);
      err_neg <= sens_sum[3];
      if (sens_cnt == '0) begin
        err <= previous_error;
      end
    end
    if (state == ST_DIV && div_done) begin
      err <= err_neg ? -$signed(div_quot) : $signed(div_quot);
    end
    if (state == ST_INTEG) begin
      diff <= DIFF_W'(err) - DIFF_W'(previous_error);
    end
    if (state == ST_SHIFT) begin
      corr <= CORR_W'(corr_sat);
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_axis_tdata <= {3'b000, err_x[lppd_pkg::POS_W-1:0], right_next, left_next};
      m_axis_tuser <= lost;
    end
  end

  assign left_step  = (SPEED_W + 1)'(left_next) - (SPEED_W + 1)'(previous_left_speed);
  assign right_step = (SPEED_W + 1)'(right_next) - (SPEED_W + 1)'(previous_right_speed);

  // No second sample is taken right after one is
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_xfer |=> !s_axis_tready)
    else $error("input taken while a sample is in progress");

  // The divider finishes only while the sequencer waits for it
  a_div_done_state: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == ST_DIV))
    else $error("divider finished outside its step");

  // The sequencer never waits on an idle divider
  a_div_alive: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV) |-> (div_busy || div_done))
    else $error("waiting on a divider that is not running");

  // Each wheel moves by at most the configured step
  a_slew_bound: assert property (@(posedge clk) disable iff (rst)
    out_load |-> ((left_step <= $signed({2'b00, step_cap}))
              && (left_step >= -$signed({2'b00, step_cap}))
              && (right_step <= $signed({2'b00, step_cap}))
              && (right_step >= -$signed({2'b00, step_cap}))))
    else $error("wheel speed step exceeds the acceleration limit");

endmodule

// File: bench/tb_line_position_pid_drive.sv
// Self-checking testbench for the line position PID drive: stream stimulus, predictor, checker.
module tb_line_position_pid_drive;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ERR_FRAC     = 8;
  localparam int GAIN_FRAC    = 8;
  localparam int SETTLE       = 40;      // beyond the worst per-sample latency
  localparam int LONG_HOLD    = 400;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int PHASES       = 8;
  localparam int PHASE_ITEMS  = 150;
  localparam logic [lppd_pkg::CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  typedef struct {
    logic signed [lppd_pkg::SPEED_W-1:0] left;
    logic signed [lppd_pkg::SPEED_W-1:0] right;
    logic signed [lppd_pkg::POS_W-1:0]   err;
    logic                                lost;
  } wheel_cmd_t;

  logic clk;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [7:0] s_axis_tdata = '0;   // [5:0] sensor_bits
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;       // [8:0] left_speed, [17:9] right_speed, [28:18] position_error
  logic [0:0] m_axis_tuser;        // [0] line_lost
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [lppd_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [lppd_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  // Predictor copy of the registers and the loop state
  longint prop_gain_cfg  = longint'(lppd_pkg::PROP_GAIN_RST);
  longint integ_gain_cfg = longint'(lppd_pkg::INTEG_GAIN_RST);
  longint deriv_gain_cfg = longint'(lppd_pkg::DERIV_GAIN_RST);
  longint cruise_cfg     = longint'(lppd_pkg::CRUISE_SPEED_RST);
  longint speed_cap_cfg  = longint'(lppd_pkg::SPEED_CAP_RST);
  longint step_cap_cfg   = longint'(lppd_pkg::STEP_CAP_RST);
  longint limit_cfg      = longint'(lppd_pkg::INTEGRAL_LIMIT_RST);
  longint trail_error = 0;
  longint error_sum   = 0;
  longint left_cmd    = 0;
  longint right_cmd   = 0;

  logic [lppd_pkg::SENSOR_W-1:0] pending_samples[$];
  wheel_cmd_t expected_cmds[$];
  int mismatches = 0;
  int cycle_count = 0;
  logic sample_moved = 1'b0;
  bit calm = 1'b0;
  bit long_hold_req = 1'b0;
  bit long_hold_used = 1'b0;
  int long_hold_left = 0;
  int gap_left = 0;
  int stall_left = 0;

  line_position_pid_drive #(
    .ERROR_FRAC_BITS(ERR_FRAC),
    .GAIN_FRAC_BITS (GAIN_FRAC)
  ) uut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic longint clamp(longint v, longint lo, longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // Saturate to the speed limit, then slew-limit against the last command
  function automatic longint steer_wheel(longint target, longint prev);
    longint s;
    s = clamp(target, -speed_cap_cfg, speed_cap_cfg);
    return clamp(s, prev - step_cap_cfg, prev + step_cap_cfg);
  endfunction

  // Advance the loop state by one sensor sample and return the wheel command
  function automatic wheel_cmd_t predict_drive(logic [lppd_pkg::SENSOR_W-1:0] bits);
    wheel_cmd_t cmd;
    longint sum, hits, err, integ, acc, corr;
    int i;
    sum = 0;
    hits = 0;
    for (i = 0; i < lppd_pkg::SENSOR_W; i++) begin
      if (bits[i]) begin
        sum += (i < 3) ? i - 3 : i - 2;
        hits++;
      end
    end
    if (hits == 0) begin
      err = trail_error;
    end else begin
      err = ((sum < 0 ? -sum : sum) << ERR_FRAC) / hits;
      if (sum < 0) err = -err;
    end
    integ = clamp(error_sum + err, -limit_cfg, limit_cfg);
    error_sum = integ;
    acc = prop_gain_cfg * err + integ_gain_cfg * integ + deriv_gain_cfg * (err - trail_error);
    corr = (acc < 0) ? -((-acc) >> (ERR_FRAC + GAIN_FRAC)) : acc >> (ERR_FRAC + GAIN_FRAC);
    trail_error = err;
    left_cmd = steer_wheel(cruise_cfg - corr, left_cmd);
    right_cmd = steer_wheel(cruise_cfg + corr, right_cmd);
    cmd.left = left_cmd[lppd_pkg::SPEED_W-1:0];
    cmd.right = right_cmd[lppd_pkg::SPEED_W-1:0];
    cmd.err = err[lppd_pkg::POS_W-1:0];
    cmd.lost = (hits == 0);
    return cmd;
  endfunction

  // One register write; leaves valid high for a following write
  task automatic write_reg(logic [lppd_pkg::CFG_IDX_W-1:0] idx,
                           logic [lppd_pkg::CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      lppd_pkg::REG_PROP_GAIN:      prop_gain_cfg = longint'(value);
      lppd_pkg::REG_INTEG_GAIN:     integ_gain_cfg = longint'(value);
      lppd_pkg::REG_DERIV_GAIN:     deriv_gain_cfg = longint'(value);
      lppd_pkg::REG_CRUISE_SPEED:   cruise_cfg = longint'(value[lppd_pkg::BYTE_W-1:0]);
      lppd_pkg::REG_SPEED_CAP:      speed_cap_cfg = longint'(value[lppd_pkg::BYTE_W-1:0]);
      lppd_pkg::REG_STEP_CAP:       step_cap_cfg = longint'(value[lppd_pkg::BYTE_W-1:0]);
      lppd_pkg::REG_INTEGRAL_LIMIT: limit_cfg = longint'(value[lppd_pkg::LIM_W-1:0]);
      default: ;
    endcase
  endtask

  // Hold until every sample is taken and every command has come back
  task automatic wait_idle();
    while (pending_samples.size() != 0 || s_axis_tvalid || expected_cmds.size() != 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Record sample transfers and predict their commands
  always @(posedge clk) begin
    if (rst) begin
      sample_moved <= 1'b0;
    end else begin
      sample_moved <= s_axis_tvalid && s_axis_tready;
      if (s_axis_tvalid && s_axis_tready)
        expected_cmds.push_back(predict_drive(s_axis_tdata[lppd_pkg::SENSOR_W-1:0]));
    end
  end

  // Offer samples, with random gaps outside the calm phases
  always @(negedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || sample_moved) begin
      if (gap_left > 0) begin
        gap_left--;
        s_axis_tvalid <= 1'b0;
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        gap_left = $urandom_range(1, 13) - 1;
        s_axis_tvalid <= 1'b0;
      end else if (pending_samples.size() != 0) begin
        s_axis_tdata <= {2'b00, pending_samples.pop_front()};
        s_axis_tvalid <= 1'b1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Drive ready with one long hold-off, and random stalls outside the calm phases
  always @(negedge clk) begin
    if (long_hold_left > 0) begin
      long_hold_left--;
      m_axis_tready <= 1'b0;
    end else if (long_hold_req && !long_hold_used) begin
      long_hold_used = 1'b1;
      long_hold_left = LONG_HOLD - 1;
      m_axis_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 13) - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Check each command transfer against the oldest prediction
  always @(posedge clk) begin
    wheel_cmd_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_cmds.size() == 0) begin
        $error("command transfer with no sample pending: tdata %h", m_axis_tdata);
        mismatches++;
      end else begin
        want = expected_cmds.pop_front();
        if (want.left !== $signed(m_axis_tdata[8:0])) begin
          $error("left_speed: expected %0d, got %0d", want.left, $signed(m_axis_tdata[8:0]));
          mismatches++;
        end
        if (want.right !== $signed(m_axis_tdata[17:9])) begin
          $error("right_speed: expected %0d, got %0d", want.right, $signed(m_axis_tdata[17:9]));
          mismatches++;
        end
        if (want.err !== $signed(m_axis_tdata[28:18])) begin
          $error("position_error: expected %0d, got %0d", want.err,
                 $signed(m_axis_tdata[28:18]));
          mismatches++;
        end
        if (want.lost !== m_axis_tuser[0]) begin
          $error("line_lost: expected %0d, got %0d", want.lost, m_axis_tuser[0]);
          mismatches++;
        end
      end
    end
  end

  // Bound the run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("** line_position_pid_drive: FAILED **");
      $finish;
    end
  end

  initial begin
    logic [lppd_pkg::SENSOR_W-1:0] directed[$];
    logic [lppd_pkg::CFG_DATA_W-1:0]
      setting[lppd_pkg::REG_PROP_GAIN:lppd_pkg::REG_INTEGRAL_LIMIT];
    logic [lppd_pkg::SENSOR_W-1:0] bits;
    int unsigned draw;
    int phase, n, width;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed samples under the reset settings: lost line first, each sensor alone,
    // all on, balanced pairs, truncation toward zero, lost streaks after an offset
    directed = {6'b000000, 6'b000001, 6'b000010, 6'b000100, 6'b001000, 6'b010000,
                6'b100000, 6'b111111, 6'b100001, 6'b000011, 6'b000111, 6'b111000,
                6'b001100, 6'b101010, 6'b010101, 6'b000000, 6'b000000, 6'b110000,
                6'b000001, 6'b011111};
    foreach (directed[k]) pending_samples.push_back(directed[k]);
    wait_idle();

    for (phase = 0; phase < PHASES; phase++) begin
      // Pick the register settings: all ones, all zeros, then random
      for (int r = lppd_pkg::REG_PROP_GAIN; r <= lppd_pkg::REG_INTEGRAL_LIMIT; r++) begin
        if (phase == 0) setting[r] = '1;
        else if (phase == 1) setting[r] = '0;
      end
      if (phase > 1) begin
        draw = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
                                           : $urandom_range(0, 16383);
        setting[lppd_pkg::REG_PROP_GAIN] = draw[lppd_pkg::CFG_DATA_W-1:0];
        draw = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
                                           : $urandom_range(0, 511);
        setting[lppd_pkg::REG_INTEG_GAIN] = draw[lppd_pkg::CFG_DATA_W-1:0];
        draw = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
                                           : $urandom_range(0, 8191);
        setting[lppd_pkg::REG_DERIV_GAIN] = draw[lppd_pkg::CFG_DATA_W-1:0];
        draw = $urandom_range(0, 255);
        setting[lppd_pkg::REG_CRUISE_SPEED] = draw[lppd_pkg::CFG_DATA_W-1:0];
        draw = $urandom_range(0, 255);
        setting[lppd_pkg::REG_SPEED_CAP] = draw[lppd_pkg::CFG_DATA_W-1:0];
        draw = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 255)
                                           : $urandom_range(1, 40);
        setting[lppd_pkg::REG_STEP_CAP] = draw[lppd_pkg::CFG_DATA_W-1:0];
        draw = $urandom_range(0, 16383);
        setting[lppd_pkg::REG_INTEGRAL_LIMIT] = draw[lppd_pkg::CFG_DATA_W-1:0];
      end
      for (int r = lppd_pkg::REG_PROP_GAIN; r <= lppd_pkg::REG_INTEGRAL_LIMIT; r++)
        write_reg(r[lppd_pkg::CFG_IDX_W-1:0], setting[r]);
      // A write past the last register must change nothing
      if (phase == 0) write_reg(REG_UNUSED, 16'h0005);
      @(negedge clk);
      cfg_valid <= 1'b0;

      calm = (phase == 4 || phase == PHASES - 1);
      n = (phase == 0) ? 120 : (phase == 1) ? 60 : PHASE_ITEMS;
      // Line-like patterns, with lost samples and arbitrary noise mixed in
      repeat (n) begin
        case ($urandom_range(0, 9))
          0, 1: bits = '0;
          2, 3, 4, 5: begin
            width = $urandom_range(1, 3);
            draw = ((1 << width) - 1) << $urandom_range(0, lppd_pkg::SENSOR_W - width);
            bits = draw[lppd_pkg::SENSOR_W-1:0];
          end
          default: begin
            draw = $urandom_range(0, 63);
            bits = draw[lppd_pkg::SENSOR_W-1:0];
          end
        endcase
        pending_samples.push_back(bits);
      end
      if (phase == 3) long_hold_req = 1'b1;
      wait_idle();
    end

    if (expected_cmds.size() != 0) mismatches++;
    if (mismatches == 0) begin
      $display("** line_position_pid_drive: PASSED **");
    end else begin
      $display("** line_position_pid_drive: FAILED **");
    end
    $finish;
  end

endmodule

// File: line_position_pid_drive.f
rtl/lppd_pkg.sv
rtl/lppd_div.sv
rtl/lppd_mac.sv
rtl/lppd_drive.sv
rtl/line_position_pid_drive.sv
bench/tb_line_position_pid_drive.sv
